FILE: src/tat_pkg.sv
// Shared constants for the three-anchor trilateration solver.
`timescale 1ns / 1ps

package tat_pkg;

    // default coordinate width, bits
    localparam int COORD_WIDTH_DEF = 24;

    // operand slice width of the pipelined multiplier
    localparam int MUL_CHUNK = 32;

endpackage

FILE: src/tat_mul.sv
// Pipelined signed multiplier: stages below NA*NB each add one slice product.
`timescale 1ns / 1ps

module tat_mul #(
    parameter int AW  = 24,
    parameter int BW  = 24,
    parameter int LAT = 1,
    parameter int SW  = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    vin,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    input  logic [SW-1:0]           sin,
    output logic                    vout,
    output logic signed [AW+BW-1:0] p,
    output logic [SW-1:0]           sout
);

    localparam int CH = tat_pkg::MUL_CHUNK;
    localparam int NA = (AW + CH - 1) / CH;
    localparam int NB = (BW + CH - 1) / CH;
    localparam int NP = NA * NB;
    localparam int PW = AW + BW;
    localparam int EW = PW + 2 * CH + 2;

    logic signed [NA*CH-1:0] a_reg    [LAT];
    logic signed [NB*CH-1:0] b_reg    [LAT];
    logic [PW-1:0]           acc_reg  [LAT];
    logic [SW-1:0]           side_reg [LAT];
    logic                    vld_reg  [LAT];

    for (genvar s = 0; s < LAT; s++) begin : g_stage
        logic signed [NA*CH-1:0] a_in;
        logic signed [NB*CH-1:0] b_in;
        logic [PW-1:0]           acc_in;
        logic [PW-1:0]           acc_next;
        logic [SW-1:0]           side_in;
        logic                    vld_in;

        if (s == 0) begin : g_first
            assign a_in    = (NA*CH)'(a);
            assign b_in    = (NB*CH)'(b);
            assign acc_in  = '0;
            assign side_in = sin;
            assign vld_in  = vin;
        end
        else begin : g_next
            assign a_in    = a_reg[s-1];
            assign b_in    = b_reg[s-1];
            assign acc_in  = acc_reg[s-1];
            assign side_in = side_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        if (s < NP) begin : g_pp
            localparam int I = s / NB;
            localparam int J = s % NB;
            logic signed [CH:0]      ca;
            logic signed [CH:0]      cb;
            logic signed [2*CH+1:0]  pp;
            logic signed [EW-1:0]    term;

            // only the top slice carries the sign
            if (I == NA - 1) begin : g_as
                assign ca = (CH+1)'(signed'(a_in[CH*I +: CH]));
            end
            else begin : g_au
                assign ca = signed'({1'b0, a_in[CH*I +: CH]});
            end
            if (J == NB - 1) begin : g_bs
                assign cb = (CH+1)'(signed'(b_in[CH*J +: CH]));
            end
            else begin : g_bu
                assign cb = signed'({1'b0, b_in[CH*J +: CH]});
            end

            assign pp       = ca * cb;
            assign term     = EW'(pp) <<< (CH * (I + J));
            assign acc_next = acc_in + term[PW-1:0];
        end
        else begin : g_pass
            assign acc_next = acc_in;
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[s] <= 1'b0;
            end
            else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                a_reg[s]    <= a_in;
                b_reg[s]    <= b_in;
                acc_reg[s]  <= acc_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign vout = vld_reg[LAT-1];
    assign p    = signed'(acc_reg[LAT-1]);
    assign sout = side_reg[LAT-1];

endmodule

FILE: src/tat_div.sv
// Pipelined restoring divider: signed, truncating, saturated to QW bits.
`timescale 1ns / 1ps

module tat_div #(
    parameter int NW = 48,
    parameter int DW = 24,
    parameter int QW = 24,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vin,
    input  logic signed [NW-1:0] a,
    input  logic signed [DW-1:0] b,
    input  logic [SW-1:0]        sin,
    output logic                 vout,
    output logic signed [QW-1:0] q,
    output logic [SW-1:0]        sout
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;
    localparam logic [QW-1:0] LIM = QW'(1) << (QW - 1);

    logic [NW-1:0]  rem_reg  [QW+1];
    logic [QW-1:0]  q_reg    [QW+1];
    logic [DW-1:0]  dv_reg   [QW+1];
    logic           neg_reg  [QW+1];
    logic           ovf_reg  [QW+1];
    logic [SW-1:0]  side_reg [QW+1];
    logic           vld_reg  [QW+1];

    logic [NW-1:0]  amag;
    logic [DW-1:0]  bmag;
    logic           ovf0;
    logic [QW-1:0]  qm;

    assign amag = a[NW-1] ? NW'(-a) : NW'(a);
    assign bmag = b[DW-1] ? DW'(-b) : DW'(b);
    // quotient of 2^QW or more saturates either way
    assign ovf0 = CW'(amag) >= (CW'(bmag) << QW);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg[0] <= 1'b0;
        end
        else if (en) begin
            vld_reg[0] <= vin;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg[0]  <= amag;
            q_reg[0]    <= '0;
            dv_reg[0]   <= bmag;
            neg_reg[0]  <= a[NW-1] ^ b[DW-1];
            ovf_reg[0]  <= ovf0;
            side_reg[0] <= sin;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_bit
        localparam int SH = QW - k;
        logic [CW-1:0] shifted;
        logic          ge;

        assign shifted = CW'(dv_reg[k-1]) << SH;
        assign ge      = CW'(rem_reg[k-1]) >= shifted;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end
            else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k]  <= ge ? NW'(CW'(rem_reg[k-1]) - shifted) : rem_reg[k-1];
                q_reg[k]    <= ge ? (q_reg[k-1] | (QW'(1) << SH)) : q_reg[k-1];
                dv_reg[k]   <= dv_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_comb begin
        if (!neg_reg[QW]) begin
            qm = (ovf_reg[QW] || q_reg[QW] > LIM - QW'(1)) ? LIM - QW'(1) : q_reg[QW];
        end
        else begin
            qm = (ovf_reg[QW] || q_reg[QW] > LIM) ? LIM : q_reg[QW];
        end
    end

    assign q    = signed'(neg_reg[QW] ? QW'(-qm) : qm);
    assign vout = vld_reg[QW];
    assign sout = side_reg[QW];

endmodule

FILE: src/three_anchor_trilateration.sv
// Top level: pipelined three-anchor position solver.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | anchor_{a,b,c}_{x,y}, range_{a,b,c}
//  out     | output    | out_valid / out_stall| found, target_x, target_y
//
// One item per cycle while out_stall does not freeze the pipe. L1 and L2 are the slice
// counts of the two multiplier groups; the quotient loop resolves one bit per stage.
// Reset clears only the valid bits. The whole pipe freezes while the output register
// holds an item and out_stall is high; in_stall follows that condition.
`timescale 1ns / 1ps

module three_anchor_trilateration #(
    parameter int COORD_WIDTH = tat_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] anchor_a_x,
    input  logic signed [COORD_WIDTH-1:0] anchor_a_y,
    input  logic [COORD_WIDTH-2:0]        range_a,
    input  logic signed [COORD_WIDTH-1:0] anchor_b_x,
    input  logic signed [COORD_WIDTH-1:0] anchor_b_y,
    input  logic [COORD_WIDTH-2:0]        range_b,
    input  logic signed [COORD_WIDTH-1:0] anchor_c_x,
    input  logic signed [COORD_WIDTH-1:0] anchor_c_y,
    input  logic [COORD_WIDTH-2:0]        range_c,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic signed [COORD_WIDTH-1:0] target_x,
    output logic signed [COORD_WIDTH-1:0] target_y
);

    localparam int W    = COORD_WIDTH;
    localparam int CH   = tat_pkg::MUL_CHUNK;
    localparam int DXW  = W + 1;
    localparam int PW   = 2 * W + 3;
    localparam int NUMW = PW + W + 2;
    localparam int DENW = 2 * W + 3;
    localparam int XNW  = PW + DENW + 1;
    localparam int XDW  = DXW + DENW + 1;
    localparam int YDW  = DENW + 1;
    localparam int NCP  = (PW + CH - 1) / CH;
    localparam int NCD  = (DXW + CH - 1) / CH;
    localparam int NCN  = (NUMW + CH - 1) / CH;
    localparam int NCE  = (DENW + CH - 1) / CH;
    localparam int L1   = NCP * NCD;
    localparam int L2A  = NCP * NCE;
    localparam int L2B  = NCD * NCN;
    localparam int L2   = (L2A > L2B) ? L2A : L2B;
    localparam int S1W  = 1 + PW + 2 * DXW;
    localparam int S2W  = 1 + NUMW + DENW;

    logic adv;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // stage 1: squares and differences
    logic                 v1_reg;
    logic [2*W-1:0]       sq_ax_reg, sq_ay_reg, sq_bx_reg, sq_by_reg, sq_cx_reg, sq_cy_reg;
    logic [2*W-3:0]       sq_ar_reg, sq_br_reg, sq_cr_reg;
    logic signed [DXW-1:0] dij1_reg, dik1_reg, djk1_reg, qij1_reg, qik1_reg, qjk1_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end
        else if (adv) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            sq_ax_reg <= anchor_a_x * anchor_a_x;
            sq_ay_reg <= anchor_a_y * anchor_a_y;
            sq_bx_reg <= anchor_b_x * anchor_b_x;
            sq_by_reg <= anchor_b_y * anchor_b_y;
            sq_cx_reg <= anchor_c_x * anchor_c_x;
            sq_cy_reg <= anchor_c_y * anchor_c_y;
            sq_ar_reg <= range_a * range_a;
            sq_br_reg <= range_b * range_b;
            sq_cr_reg <= range_c * range_c;
            dij1_reg  <= DXW'(anchor_a_x) - DXW'(anchor_b_x);
            dik1_reg  <= DXW'(anchor_a_x) - DXW'(anchor_c_x);
            djk1_reg  <= DXW'(anchor_b_x) - DXW'(anchor_c_x);
            qij1_reg  <= DXW'(anchor_b_y) - DXW'(anchor_a_y);
            qik1_reg  <= DXW'(anchor_c_y) - DXW'(anchor_a_y);
            qjk1_reg  <= DXW'(anchor_c_y) - DXW'(anchor_b_y);
        end
    end

    // stage 2: pair line constants
    function automatic logic signed [PW-1:0] pair_p(
        input logic [2*W-1:0] sxa,
        input logic [2*W-1:0] sya,
        input logic [2*W-3:0] sra,
        input logic [2*W-1:0] sxb,
        input logic [2*W-1:0] syb,
        input logic [2*W-3:0] srb
    );
        pair_p = signed'(PW'(sxa)) - signed'(PW'(sxb)) + signed'(PW'(sya))
               - signed'(PW'(syb)) - signed'(PW'(sra)) + signed'(PW'(srb));
    endfunction

    logic                  v2_reg;
    logic signed [PW-1:0]  pij_reg, pik_reg, pjk_reg;
    logic signed [DXW-1:0] dij2_reg, dik2_reg, djk2_reg, qij2_reg, qik2_reg, qjk2_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v2_reg <= 1'b0;
        end
        else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            pij_reg  <= pair_p(sq_ax_reg, sq_ay_reg, sq_ar_reg, sq_bx_reg, sq_by_reg, sq_br_reg);
            pik_reg  <= pair_p(sq_ax_reg, sq_ay_reg, sq_ar_reg, sq_cx_reg, sq_cy_reg, sq_cr_reg);
            pjk_reg  <= pair_p(sq_bx_reg, sq_by_reg, sq_br_reg, sq_cx_reg, sq_cy_reg, sq_cr_reg);
            dij2_reg <= dij1_reg;
            dik2_reg <= dik1_reg;
            djk2_reg <= djk1_reg;
            qij2_reg <= qij1_reg;
            qik2_reg <= qik1_reg;
            qjk2_reg <= qjk1_reg;
        end
    end

    // stage 3: pick the two pair lines; line 1 also gives x
    logic                  v3_reg, ok3_reg;
    logic signed [PW-1:0]  p1_next, p2_next, p1_reg, p2_reg;
    logic signed [DXW-1:0] q1_next, q2_next, d1_next, d2_next;
    logic signed [DXW-1:0] q1_reg, q2_reg, d1_reg, d2_reg;

    always_comb begin
        if (dij2_reg != '0) begin
            p1_next = pij_reg;
            q1_next = qij2_reg;
            d1_next = dij2_reg;
            if (dik2_reg != '0) begin
                p2_next = pik_reg;
                q2_next = qik2_reg;
                d2_next = dik2_reg;
            end
            else begin
                p2_next = pjk_reg;
                q2_next = qjk2_reg;
                d2_next = djk2_reg;
            end
        end
        else begin
            p1_next = pik_reg;
            q1_next = qik2_reg;
            d1_next = dik2_reg;
            p2_next = pjk_reg;
            q2_next = qjk2_reg;
            d2_next = djk2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v3_reg <= 1'b0;
        end
        else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            ok3_reg <= (dij2_reg != '0) || (dik2_reg != '0);
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            q1_reg  <= q1_next;
            q2_reg  <= q2_next;
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
        end
    end

    // multiplier group 1: y numerator and half denominator
    logic                     m1_v;
    logic signed [PW+DXW-1:0] m1_p, m2_p;
    logic signed [2*DXW-1:0]  m3_p, m4_p;
    logic [S1W-1:0]           m1_side;

    tat_mul #(.AW(PW), .BW(DXW), .LAT(L1), .SW(S1W)) u_mul_pd1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v3_reg),
        .a(p1_reg), .b(d2_reg), .sin({ok3_reg, p1_reg, q1_reg, d1_reg}),
        .vout(m1_v), .p(m1_p), .sout(m1_side)
    );

    tat_mul #(.AW(PW), .BW(DXW), .LAT(L1), .SW(1)) u_mul_pd2 (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v3_reg),
        .a(p2_reg), .b(d1_reg), .sin(1'b0),
        .vout(), .p(m2_p), .sout()
    );

    tat_mul #(.AW(DXW), .BW(DXW), .LAT(L1), .SW(1)) u_mul_qd1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v3_reg),
        .a(q2_reg), .b(d1_reg), .sin(1'b0),
        .vout(), .p(m3_p), .sout()
    );

    tat_mul #(.AW(DXW), .BW(DXW), .LAT(L1), .SW(1)) u_mul_qd2 (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v3_reg),
        .a(q1_reg), .b(d2_reg), .sin(1'b0),
        .vout(), .p(m4_p), .sout()
    );

    // stage 4: num = P1*D2 - P2*D1, den = Q2*D1 - Q1*D2 (y = num / 2den)
    logic                   v4_reg, ok4_reg;
    logic signed [NUMW-1:0] num_reg;
    logic signed [DENW-1:0] den_reg;
    logic signed [PW-1:0]   p1_4_reg;
    logic signed [DXW-1:0]  q1_4_reg, d1_4_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v4_reg <= 1'b0;
        end
        else if (adv) begin
            v4_reg <= m1_v;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            num_reg  <= NUMW'(m1_p) - NUMW'(m2_p);
            den_reg  <= DENW'(m3_p) - DENW'(m4_p);
            ok4_reg  <= m1_side[S1W-1];
            p1_4_reg <= signed'(m1_side[2*DXW +: PW]);
            q1_4_reg <= signed'(m1_side[DXW +: DXW]);
            d1_4_reg <= signed'(m1_side[0 +: DXW]);
        end
    end

    // multiplier group 2: x = (P1*den + Q1*num) / (2*D1*den)
    logic                      m5_v;
    logic signed [PW+DENW-1:0] m5_p;
    logic signed [DXW+NUMW-1:0] m6_p;
    logic signed [DXW+DENW-1:0] m7_p;
    logic [S2W-1:0]            m5_side;

    tat_mul #(.AW(PW), .BW(DENW), .LAT(L2), .SW(S2W)) u_mul_pden (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v4_reg),
        .a(p1_4_reg), .b(den_reg), .sin({ok4_reg, num_reg, den_reg}),
        .vout(m5_v), .p(m5_p), .sout(m5_side)
    );

    tat_mul #(.AW(DXW), .BW(NUMW), .LAT(L2), .SW(1)) u_mul_qnum (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v4_reg),
        .a(q1_4_reg), .b(num_reg), .sin(1'b0),
        .vout(), .p(m6_p), .sout()
    );

    tat_mul #(.AW(DXW), .BW(DENW), .LAT(L2), .SW(1)) u_mul_dden (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v4_reg),
        .a(d1_4_reg), .b(den_reg), .sin(1'b0),
        .vout(), .p(m7_p), .sout()
    );

    // stage 5: divider operands
    logic                   v5_reg, found5_reg;
    logic signed [XNW-1:0]  xn_reg;
    logic signed [XDW-1:0]  xd_reg;
    logic signed [NUMW-1:0] yn_reg;
    logic signed [YDW-1:0]  yd_reg;
    logic signed [DENW-1:0] den5;

    assign den5 = signed'(m5_side[0 +: DENW]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v5_reg <= 1'b0;
        end
        else if (adv) begin
            v5_reg <= m5_v;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            xn_reg     <= XNW'(m5_p) + XNW'(m6_p);
            xd_reg     <= XDW'(m7_p) <<< 1;
            yn_reg     <= signed'(m5_side[DENW +: NUMW]);
            yd_reg     <= YDW'(den5) <<< 1;
            found5_reg <= m5_side[S2W-1] && (den5 != '0);
        end
    end

    // dividers
    logic                dx_v;
    logic                dx_found;
    logic signed [W-1:0] qx, qy;

    tat_div #(.NW(XNW), .DW(XDW), .QW(W), .SW(1)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v5_reg),
        .a(xn_reg), .b(xd_reg), .sin(found5_reg),
        .vout(dx_v), .q(qx), .sout(dx_found)
    );

    tat_div #(.NW(NUMW), .DW(YDW), .QW(W), .SW(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(v5_reg),
        .a(yn_reg), .b(yd_reg), .sin(1'b0),
        .vout(), .q(qy), .sout()
    );

    // output register
    logic                out_vld_reg, found_reg;
    logic signed [W-1:0] x_reg, y_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end
        else if (adv) begin
            out_vld_reg <= dx_v;
        end
    end

    always_ff @(posedge clk) begin
        if (adv && dx_v) begin
            found_reg <= dx_found;
            x_reg     <= dx_found ? qx : '0;
            y_reg     <= dx_found ? qy : '0;
        end
    end

    assign out_valid = out_vld_reg;
    assign found     = found_reg;
    assign target_x  = x_reg;
    assign target_y  = y_reg;

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> target_x == '0 && target_y == '0)
        else $error("unsolved item carries a nonzero position");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(v1_reg) && $stable(v4_reg) && $stable(v5_reg))
        else $error("pipeline moved while stalled");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty output register");

endmodule
